// ===== rtl/rgbhsl_pkg.sv =====
// rgbhsl_pkg: widths, constants and the long-division step functions
// for the RGB to HSL converter. No dependencies.
package rgbhsl_pkg;

  localparam int COMP_W   = 8;
  localparam int HUE_W    = 9;
  localparam int SAT_W    = 16;
  localparam int LIGHT_W  = 7;
  localparam int REM_W    = 10;
  localparam int SATQ_W   = 17;
  localparam int HUEQ_W   = 9;
  localparam int DIV_STG  = 6;
  localparam int STEPS    = 3;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [6:0]  LIGHT_HALF = 7'd50;
  localparam logic [9:0]  SUM_FULL   = 10'd510;
  localparam logic [8:0]  HUE_WRAP   = 9'd360;
  localparam logic [15:0] SAT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [SATQ_W-1:0] q;
  } sat_div_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [HUEQ_W-1:0] q;
  } hue_div_t;

  // up to three restoring steps: shift in the top quotient-register bit
  function automatic sat_div_t sat_steps(sat_div_t a, logic [REM_W-1:0] dv, int n);
    sat_div_t  r;
    logic [REM_W:0] t;
    r = a;
    for (int i = 0; i < STEPS; i++) begin
      if (i < n) begin
        t = {r.rem, r.q[SATQ_W-1]};
        r.q = {r.q[SATQ_W-2:0], 1'b0};
        if (t >= {1'b0, dv}) begin
          t = t - {1'b0, dv};
          r.q[0] = 1'b1;
        end
        r.rem = t[REM_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic hue_div_t hue_steps(hue_div_t a, logic [REM_W-1:0] dv, int n);
    hue_div_t  r;
    logic [REM_W:0] t;
    r = a;
    for (int i = 0; i < STEPS; i++) begin
      if (i < n) begin
        t = {r.rem, r.q[HUEQ_W-1]};
        r.q = {r.q[HUEQ_W-2:0], 1'b0};
        if (t >= {1'b0, dv}) begin
          t = t - {1'b0, dv};
          r.q[0] = 1'b1;
        end
        r.rem = t[REM_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/rgb_to_hsl_converter.sv =====
// rgb_to_hsl_converter: eleven-stage pipelined RGB to HSL conversion.
// Depends on rgbhsl_pkg (widths, constants, division step functions).
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  input   | in_valid / in_ready   | red_in, green_in, blue_in
//  output  | out_valid / out_ready | hue_deg, sat_frac, light_pct
//
// One request per cycle unless the pipeline is full and the output is stalled.
// Depth set by the saturation long division, three quotient bits a stage (two in the last).
// rst (synchronous) empties the pipeline; no clearing pass.
// Each stage holds while the one after it is full and stalled.
module rgb_to_hsl_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] hue_deg,
  output logic [15:0] sat_frac,
  output logic [6:0] light_pct
);

  localparam int NSTG = 5 + rgbhsl_pkg::DIV_STG;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) adv[k] = !v[k] || adv[k+1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) if (adv[k]) v[k] <= v[k-1];
    end
  end

  // stage 1: input register
  logic [7:0] r1, g1, b1;
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r1 <= red_in;
      g1 <= green_in;
      b1 <= blue_in;
    end
  end

  // stage 2: extremes, hue numerator, lightness numerator
  logic [7:0]  mx, mn;
  logic [1:0]  sel;
  logic signed [18:0] t_c;
  logic [7:0]  d2;
  logic [8:0]  s2;
  logic [16:0] tmag2;
  logic        neg2;
  logic [15:0] x2;

  always_comb begin
    mx = r1;
    mn = r1;
    if (g1 > mx) mx = g1;
    if (b1 > mx) mx = b1;
    if (g1 < mn) mn = g1;
    if (b1 < mn) mn = b1;
    if (r1 == mx) sel = rgbhsl_pkg::SEL_RED;
    else if (g1 == mx) sel = rgbhsl_pkg::SEL_GREEN;
    else sel = rgbhsl_pkg::SEL_BLUE;
    case (sel)
      rgbhsl_pkg::SEL_RED:
        t_c = 19'sd60 * ($signed({11'd0, g1}) - $signed({11'd0, b1}));
      rgbhsl_pkg::SEL_GREEN:
        t_c = 19'sd120 * $signed({11'd0, mx - mn})
            + 19'sd60 * ($signed({11'd0, b1}) - $signed({11'd0, r1}));
      default:
        t_c = 19'sd240 * $signed({11'd0, mx - mn})
            + 19'sd60 * ($signed({11'd0, r1}) - $signed({11'd0, g1}));
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d2    <= mx - mn;
      s2    <= {1'b0, mx} + {1'b0, mn};
      neg2  <= t_c[18];
      tmag2 <= t_c[18] ? 17'(-t_c) : t_c[16:0];
      x2    <= 16'(({7'd0, mx} + {7'd0, mn}) * 16'd100 + 16'd255);
    end
  end

  // stage 3: reciprocal estimate of floor(x / 510)
  logic [7:0]  d3;
  logic [8:0]  s3;
  logic [16:0] tmag3;
  logic        neg3;
  logic [14:0] y3;
  logic [7:0]  q3;
  logic [23:0] p_c;
  assign p_c = {9'd0, x2[15:1]} * 24'd257;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d3    <= d2;
      s3    <= s2;
      tmag3 <= tmag2;
      neg3  <= neg2;
      y3    <= x2[15:1];
      q3    <= p_c[23:16];
    end
  end

  // stage 4: lightness correction, divider set-up
  logic [15:0] prod_c;
  logic [15:0] resid_c;
  logic [6:0]  light_c;
  logic [8:0]  den_c;
  logic [17:0] hnum_c;

  always_comb begin
    prod_c  = {q3, 8'd0} - {8'd0, q3};
    resid_c = {1'b0, y3} - prod_c;
    light_c = (resid_c >= 16'd255) ? 7'(q3 + 8'd1) : q3[6:0];
    den_c   = (light_c <= rgbhsl_pkg::LIGHT_HALF) ? s3
            : 9'(rgbhsl_pkg::SUM_FULL - {1'b0, s3});
    hnum_c  = {tmag3, 1'b0} + {10'd0, d3};
  end

  rgbhsl_pkg::sat_div_t sd [0:rgbhsl_pkg::DIV_STG];
  rgbhsl_pkg::hue_div_t hd [0:rgbhsl_pkg::DIV_STG];
  logic [9:0] sdv [0:rgbhsl_pkg::DIV_STG];
  logic [9:0] hdv [0:rgbhsl_pkg::DIV_STG];
  logic       negp [0:rgbhsl_pkg::DIV_STG];
  logic       grey [0:rgbhsl_pkg::DIV_STG];
  logic [6:0] lgt  [0:rgbhsl_pkg::DIV_STG];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sd[0].rem <= {2'd0, d3};
      sd[0].q   <= {8'd0, den_c};
      sdv[0]    <= {den_c, 1'b0};
      hd[0].rem <= {1'b0, hnum_c[17:9]};
      hd[0].q   <= hnum_c[8:0];
      hdv[0]    <= {1'b0, d3, 1'b0};
      negp[0]   <= neg3;
      grey[0]   <= (d3 == 8'd0);
      lgt[0]    <= light_c;
    end
  end

  // stages 5..10: saturation quotient three bits a stage (two in stage 10); hue quotient three bits a stage in 5..7
  for (genvar k = 1; k <= rgbhsl_pkg::DIV_STG; k++) begin : g_div
    localparam int SN = (k == rgbhsl_pkg::DIV_STG) ? 2 : 3;
    localparam int HN = (k <= 3) ? 3 : 0;
    always_ff @(posedge clk) begin
      if (adv[3+k]) begin
        sd[k]   <= rgbhsl_pkg::sat_steps(sd[k-1], sdv[k-1], SN);
        hd[k]   <= rgbhsl_pkg::hue_steps(hd[k-1], hdv[k-1], HN);
        sdv[k]  <= sdv[k-1];
        hdv[k]  <= hdv[k-1];
        negp[k] <= negp[k-1];
        grey[k] <= grey[k-1];
        lgt[k]  <= lgt[k-1];
      end
    end
  end

  // stage 11: output register
  localparam int L = rgbhsl_pkg::DIV_STG;
  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      light_pct <= lgt[L];
      if (grey[L]) begin
        hue_deg  <= '0;
        sat_frac <= '0;
      end else begin
        sat_frac <= sd[L].q[16] ? rgbhsl_pkg::SAT_MAX : sd[L].q[15:0];
        if (negp[L] && hd[L].q != 9'd0) hue_deg <= rgbhsl_pkg::HUE_WRAP - hd[L].q;
        else hue_deg <= hd[L].q;
      end
    end
  end

  assign out_valid = v[NSTG-1];

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue_deg < 9'd360) else $error("hue out of range");
  a_light_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> light_pct <= 7'd100) else $error("lightness out of range");
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0]) else $error("request lost at entry");
  a_grey_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sat_frac == 16'd0) |-> hue_deg == 9'd0)
    else $error("zero saturation with non-zero hue");

endmodule
